@@ hw/rtl/bsd_pkg.sv @@
// Shared types and codes for the bounded stack with duplicate delete.
// Holds the request and response structs, operation codes and cell control.
// No dependencies.
package bsd_pkg;

  localparam int FUNC_W      = 3;
  localparam int VALUE_W     = 16;
  localparam int COUNT_W     = 5;
  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic [FUNC_W-1:0] FUNC_PUSH        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_UNIQUE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP         = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PEEK        = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEL_FIRST   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DEL_ALL     = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR       = 3'd6;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t CELL_HOLD     = 2'd0;
  localparam cell_op_t CELL_SHIFT_DN = 2'd1;
  localparam cell_op_t CELL_SHIFT_UP = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               has_data;
    logic [COUNT_W-1:0] done_count;
    logic               last;
  } out_rsp_t;

  typedef struct packed {
    cell_op_t op;
    logic     ins;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/bounded_stack_with_dedup_delete_core.sv @@
// Bounded LIFO stack built as a chain of cells, newest entry in the head cell.
// Depends on bsd_pkg and bsd_cell.
//
// A push is accepted, then every cell moves one place toward the bottom, then
// the result is presented. Pop and peek with a nonzero count, and delete and
// push-unique on a non-empty stack, run a scan in which the chain moves one
// place toward the head per cycle, unless the result side stalls an emitted
// entry, and the head entry either drops out or wraps back to the last live
// position. Pop and peek emit each entry during the scan; push-unique of a new
// value then pushes it. Clear, undefined codes and requests with nothing to
// scan go straight to the result, push-unique on an empty stack to the push.
// The next request is taken once the last result is in the output register.
// The stored entries need no clearing after reset.
module bounded_stack_with_dedup_delete_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bsd_pkg::in_req_t                in_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bsd_pkg::out_rsp_t               out_rsp,
  input  logic                            cfg_wr_en,
  input  logic [bsd_pkg::CAP_W-1:0]       cfg_wr_data
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = (FW > bsd_pkg::COUNT_W) ? FW : bsd_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [FW-1:0]                 fill_r, fill_nxt;
  logic [FW-1:0]                 step_r, step_nxt;
  logic [FW-1:0]                 steps_r, steps_nxt;
  logic [bsd_pkg::COUNT_W-1:0]   n_r, n_nxt;
  logic [bsd_pkg::COUNT_W-1:0]   done_r, done_nxt;
  logic                          found_r, found_nxt;
  logic [bsd_pkg::FUNC_W-1:0]    func_r, func_nxt;
  logic [DATA_WIDTH-1:0]         val_r, val_nxt;
  logic [bsd_pkg::CAP_W-1:0]     cap_r, cap_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bsd_pkg::out_rsp_t             out_rsp_r, out_rsp_nxt;

  logic [DATA_WIDTH-1:0]         cell_q [DEPTH];
  bsd_pkg::cell_ctrl_t           cell_ctrl [DEPTH];
  bsd_pkg::cell_op_t             cell_op;
  logic                          ins_en;
  logic [IW-1:0]                 ins_idx;

  logic [DATA_WIDTH-1:0]         in_val_ext;
  logic [bsd_pkg::VALUE_W-1:0]   head_data;
  logic                          head_match;
  logic                          keep;
  logic                          is_delete;
  logic                          emit_now;
  logic                          out_free;
  logic                          step_go;
  logic [FW-1:0]                 step_inc;
  logic [CW-1:0]                 cap_ext;
  logic [FW-1:0]                 eff_cap;
  logic [CW-1:0]                 n_min;
  logic [CW-1:0]                 fill_ext;
  logic [CW-1:0]                 cnt_ext;

  // Values wider than the request field are zero extended; narrower ones
  // keep the low bits.
  generate
    if (DATA_WIDTH >= bsd_pkg::VALUE_W) begin : g_wide
      assign in_val_ext = DATA_WIDTH'(in_req.value);
      assign head_data  = cell_q[0][bsd_pkg::VALUE_W-1:0];
    end else begin : g_narrow
      assign in_val_ext = in_req.value[DATA_WIDTH-1:0];
      assign head_data  = bsd_pkg::VALUE_W'(cell_q[0]);
    end
  endgenerate

  // The recirculated head goes in at the last live position.
  assign ins_idx = IW'(fill_r - FW'(1));

  generate
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_d;
      logic [DATA_WIDTH-1:0] next_d;

      if (j == 0) begin : g_head
        assign prev_d = val_r;
      end else begin : g_body
        assign prev_d = cell_q[j-1];
      end
      if (j == DEPTH - 1) begin : g_tail
        assign next_d = cell_q[0];
      end else begin : g_mid
        assign next_d = cell_q[j+1];
      end

      assign cell_ctrl[j].op  = cell_op;
      assign cell_ctrl[j].ins = ins_en && (ins_idx == IW'(j));

      bsd_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl[j]),
        .prev_d  (prev_d),
        .next_d  (next_d),
        .bcast_d (cell_q[0]),
        .q       (cell_q[j])
      );
    end
  endgenerate

  // Capacity zero acts as one, and anything above the chain length as DEPTH.
  always_comb begin
    cap_ext = CW'(cap_r);
    if (cap_r == '0) begin
      eff_cap = FW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = FW'(DEPTH);
    end else begin
      eff_cap = FW'(cap_r);
    end
  end

  always_comb begin
    fill_ext = CW'(fill_r);
    cnt_ext  = CW'(in_req.count);
    n_min    = (cnt_ext < fill_ext) ? cnt_ext : fill_ext;
    if (n_min > CW'(bsd_pkg::MAX_RESULTS)) begin
      n_min = CW'(bsd_pkg::MAX_RESULTS);
    end
  end

  assign head_match = (cell_q[0] == val_r);
  assign is_delete  = (func_r == bsd_pkg::FUNC_DEL_FIRST) ||
                      (func_r == bsd_pkg::FUNC_DEL_ALL);

  always_comb begin
    unique case (func_r)
      bsd_pkg::FUNC_POP:       keep = 1'b0;
      bsd_pkg::FUNC_DEL_FIRST: keep = !(head_match && (done_r == '0));
      bsd_pkg::FUNC_DEL_ALL:   keep = !head_match;
      default:                 keep = 1'b1;
    endcase
  end

  assign emit_now = ((func_r == bsd_pkg::FUNC_POP) || (func_r == bsd_pkg::FUNC_PEEK)) &&
                    (CW'(step_r) < CW'(n_r));
  assign out_free = !out_valid_r || out_ready;
  assign step_go  = (state_r == ST_SCAN) && (!emit_now || out_free);
  assign step_inc = step_r + FW'(1);
  assign in_ready = (state_r == ST_IDLE);
  assign cap_nxt  = cfg_wr_en ? cfg_wr_data : cap_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    step_nxt      = step_r;
    steps_nxt     = steps_r;
    n_nxt         = n_r;
    done_nxt      = done_r;
    found_nxt     = found_r;
    func_nxt      = func_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    cell_op       = bsd_pkg::CELL_HOLD;
    ins_en        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_req.func;
          val_nxt   = in_val_ext;
          n_nxt     = bsd_pkg::COUNT_W'(n_min);
          step_nxt  = '0;
          steps_nxt = fill_r;
          done_nxt  = '0;
          found_nxt = 1'b0;
          unique case (in_req.func)
            bsd_pkg::FUNC_PUSH: begin
              state_nxt = ST_PUSH;
            end
            bsd_pkg::FUNC_PUSH_UNIQUE: begin
              state_nxt = (fill_r == '0) ? ST_PUSH : ST_SCAN;
            end
            bsd_pkg::FUNC_POP: begin
              steps_nxt = FW'(n_min);
              state_nxt = (n_min == '0) ? ST_FIN : ST_SCAN;
            end
            bsd_pkg::FUNC_PEEK: begin
              state_nxt = (n_min == '0) ? ST_FIN : ST_SCAN;
            end
            bsd_pkg::FUNC_DEL_FIRST, bsd_pkg::FUNC_DEL_ALL: begin
              state_nxt = (fill_r == '0) ? ST_FIN : ST_SCAN;
            end
            bsd_pkg::FUNC_CLEAR: begin
              fill_nxt  = '0;
              state_nxt = ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (step_go) begin
          cell_op = bsd_pkg::CELL_SHIFT_UP;
          ins_en  = keep;
          if (!keep) begin
            fill_nxt = fill_r - FW'(1);
          end
          // The delete count holds at its field maximum on long chains.
          if (is_delete && !keep && (done_r != '1)) begin
            done_nxt = done_r + bsd_pkg::COUNT_W'(1);
          end
          if ((func_r == bsd_pkg::FUNC_PUSH_UNIQUE) && head_match) begin
            found_nxt = 1'b1;
          end
          if (emit_now) begin
            out_valid_nxt          = 1'b1;
            out_rsp_nxt.data       = head_data;
            out_rsp_nxt.has_data   = 1'b1;
            out_rsp_nxt.done_count = bsd_pkg::COUNT_W'(step_inc);
            out_rsp_nxt.last       = (bsd_pkg::COUNT_W'(step_inc) == n_r);
          end
          step_nxt = step_inc;
          if (step_inc == steps_r) begin
            unique case (func_r)
              bsd_pkg::FUNC_PUSH_UNIQUE: begin
                state_nxt = (found_r || head_match) ? ST_FIN : ST_PUSH;
              end
              bsd_pkg::FUNC_POP, bsd_pkg::FUNC_PEEK: begin
                state_nxt = ST_IDLE;
              end
              default: begin
                state_nxt = ST_FIN;
              end
            endcase
          end
        end
      end

      ST_PUSH: begin
        // A push onto a full stack keeps the newest capacity minus one
        // entries; the rest fall off the bottom by lowering the fill.
        cell_op   = bsd_pkg::CELL_SHIFT_DN;
        fill_nxt  = (fill_r >= eff_cap) ? eff_cap : fill_r + FW'(1);
        done_nxt  = bsd_pkg::COUNT_W'(1);
        state_nxt = ST_FIN;
      end

      default: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.data       = '0;
          out_rsp_nxt.has_data   = 1'b0;
          out_rsp_nxt.done_count = done_r;
          out_rsp_nxt.last       = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cap_r       <= bsd_pkg::CAP_W'(bsd_pkg::CAP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r    <= step_nxt;
    steps_r   <= steps_nxt;
    n_r       <= n_nxt;
    done_r    <= done_nxt;
    found_r   <= found_nxt;
    func_r    <= func_nxt;
    val_r     <= val_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill level above chain length");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (fill_r != '0))
    else $error("scan running on an empty stack");

  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (step_r < steps_r))
    else $error("scan step past its end");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |=> (fill_r != '0))
    else $error("stack empty right after a push");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.has_data) |-> (out_rsp.done_count != '0))
    else $error("returned entry with zero count");
`endif

endmodule

@@ hw/rtl/bsd_cell.sv @@
// One storage cell of the stack chain.
// Depends on bsd_pkg for the cell control struct and its operation codes.
module bsd_cell #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                   clk,
  input  bsd_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  prev_d,
  input  logic [DATA_WIDTH-1:0]  next_d,
  input  logic [DATA_WIDTH-1:0]  bcast_d,
  output logic [DATA_WIDTH-1:0]  q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Shifting down moves toward the bottom on a push; shifting up moves toward
  // the top during a scan, where the cell flagged for insertion takes the recirculated head.
  always_comb begin
    unique case (ctrl.op)
      bsd_pkg::CELL_SHIFT_DN: data_nxt = prev_d;
      bsd_pkg::CELL_SHIFT_UP: data_nxt = ctrl.ins ? bcast_d : next_d;
      default:                data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

@@ dv/bounded_stack_checker.sv @@
`timescale 1ns / 100ps
// Checker for bounded_stack_with_dedup_delete_core: keeps its own copy of the stack,
// predicts the responses of every accepted request and compares them in order.
// Depends on bsd_pkg only.
module bounded_stack_checker #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  bsd_pkg::in_req_t          in_req,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  bsd_pkg::out_rsp_t         out_rsp,
  input  logic                      cfg_wr_en,
  input  logic [bsd_pkg::CAP_W-1:0] cfg_wr_data,
  output int                        mismatches,
  output int                        rsp_waiting,
  output int                        rsp_seen
);

  logic [bsd_pkg::VALUE_W-1:0] stack_mem [DEPTH];
  int                          stack_fill;
  logic [bsd_pkg::CAP_W-1:0]   cap_reg;
  bsd_pkg::out_rsp_t           rsp_due [$];
  int                          fail_cnt;
  int                          seen_cnt;

  function automatic int eff_cap();
    if (cap_reg == '0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  // A full stack drops its oldest entries so that the new value fits on top.
  function automatic void push_value(logic [bsd_pkg::VALUE_W-1:0] v);
    int cap;
    int drop;
    cap = eff_cap();
    if (stack_fill >= cap) begin
      drop = stack_fill - cap + 1;
      for (int i = 0; i < cap - 1; i++) stack_mem[i] = stack_mem[i + drop];
      stack_fill = cap - 1;
    end
    stack_mem[stack_fill] = v;
    stack_fill++;
  endfunction

  function automatic bit holds_value(logic [bsd_pkg::VALUE_W-1:0] v);
    for (int i = 0; i < stack_fill; i++) begin
      if (stack_mem[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Walks from the top down, closing the gap left by each removed entry.
  function automatic int drop_matches(logic [bsd_pkg::VALUE_W-1:0] v, bit every);
    int n;
    int pos;
    n = 0;
    pos = stack_fill;
    while (pos > 0) begin
      pos--;
      if (stack_mem[pos] == v) begin
        for (int i = pos; i + 1 < stack_fill; i++) stack_mem[i] = stack_mem[i + 1];
        stack_fill--;
        n++;
        if (!every) break;
      end
    end
    return n;
  endfunction

  function automatic void add_rsp(logic [bsd_pkg::VALUE_W-1:0] d, logic h, int done,
                                  logic l);
    bsd_pkg::out_rsp_t r;
    if (done > 31) done = 31;
    r.data       = d;
    r.has_data   = h;
    r.done_count = bsd_pkg::COUNT_W'(done);
    r.last       = l;
    rsp_due.push_back(r);
  endfunction

  function automatic void apply_request(bsd_pkg::in_req_t r);
    int n;
    case (r.func)
      bsd_pkg::FUNC_PUSH: begin
        push_value(r.value);
        add_rsp('0, 1'b0, 1, 1'b1);
      end
      bsd_pkg::FUNC_PUSH_UNIQUE: begin
        if (holds_value(r.value)) begin
          add_rsp('0, 1'b0, 0, 1'b1);
        end else begin
          push_value(r.value);
          add_rsp('0, 1'b0, 1, 1'b1);
        end
      end
      bsd_pkg::FUNC_POP, bsd_pkg::FUNC_PEEK: begin
        n = int'(r.count);
        if (n > stack_fill) n = stack_fill;
        if (n > bsd_pkg::MAX_RESULTS) n = bsd_pkg::MAX_RESULTS;
        if (n == 0) begin
          add_rsp('0, 1'b0, 0, 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            add_rsp(stack_mem[stack_fill - 1 - k], 1'b1, k + 1, k + 1 == n);
          end
          if (r.func == bsd_pkg::FUNC_POP) stack_fill -= n;
        end
      end
      bsd_pkg::FUNC_DEL_FIRST, bsd_pkg::FUNC_DEL_ALL: begin
        n = drop_matches(r.value, r.func == bsd_pkg::FUNC_DEL_ALL);
        add_rsp('0, 1'b0, n, 1'b1);
      end
      bsd_pkg::FUNC_CLEAR: begin
        stack_fill = 0;
        add_rsp('0, 1'b0, 0, 1'b1);
      end
      default: begin
        add_rsp('0, 1'b0, 0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    fail_cnt++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  initial begin
    fail_cnt = 0;
    seen_cnt = 0;
    stack_fill = 0;
    cap_reg = bsd_pkg::CAP_RESET;
  end

  always @(posedge clk) begin
    bsd_pkg::out_rsp_t want;
    if (!rst_n) begin
      stack_fill = 0;
      cap_reg = bsd_pkg::CAP_RESET;
      rsp_due.delete();
    end else begin
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (out_valid && out_ready) begin
        seen_cnt++;
        if (rsp_due.size() == 0) begin
          report_mismatch($sformatf("response %p with no request pending", out_rsp));
        end else begin
          want = rsp_due.pop_front();
          if (out_rsp.data !== want.data)
            report_mismatch($sformatf("data %h, predicted %h", out_rsp.data, want.data));
          if (out_rsp.has_data !== want.has_data)
            report_mismatch($sformatf("has_data %b, predicted %b",
                                      out_rsp.has_data, want.has_data));
          if (out_rsp.done_count !== want.done_count)
            report_mismatch($sformatf("done_count %0d, predicted %0d",
                                      out_rsp.done_count, want.done_count));
          if (out_rsp.last !== want.last)
            report_mismatch($sformatf("last %b, predicted %b", out_rsp.last, want.last));
        end
      end
      if (in_valid && in_ready) apply_request(in_req);
    end
    // Published with nonblocking updates so the stimulus side reads them race free.
    mismatches  <= fail_cnt;
    rsp_waiting <= rsp_due.size();
    rsp_seen    <= seen_cnt;
  end

endmodule

@@ dv/bounded_stack_with_dedup_delete_core_test.sv @@
`timescale 1ns / 100ps
// Top of the stack testbench: clock, reset, request and capacity stimulus, and verdict.
// Depends on bsd_pkg, bounded_stack_with_dedup_delete_core and bounded_stack_checker.
module bounded_stack_with_dedup_delete_core_test;

  localparam int RUN_LIMIT    = 400000;
  localparam int CHOKE_CYCLES = 300;
  localparam int PHASE_REQS   = 35;
  localparam int N_PHASES     = 7;
  localparam logic [bsd_pkg::FUNC_W-1:0] FUNC_UNDEF = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  bsd_pkg::in_req_t          in_req;
  logic                      out_valid;
  logic                      out_ready;
  bsd_pkg::out_rsp_t         out_rsp;
  logic                      cfg_wr_en;
  logic [bsd_pkg::CAP_W-1:0] cfg_wr_data;

  int mismatches;
  int rsp_waiting;
  int rsp_seen;
  int cycles;
  int n_sent;
  bit calm;
  bit choke_go;

  logic [bsd_pkg::CAP_W-1:0]   cap_plan [N_PHASES] = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31,
                                                       5'd17, 5'd9};
  logic [bsd_pkg::VALUE_W-1:0] value_pool [6] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                                  16'h1234, 16'hA5A5};

  bounded_stack_with_dedup_delete_core #(
    .DEPTH      (16),
    .DATA_WIDTH (16)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bounded_stack_checker #(
    .DEPTH (16)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .rsp_waiting (rsp_waiting),
    .rsp_seen    (rsp_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d responses outstanding",
             cycles, rsp_waiting);
    $display("end of test: mismatches");
    $finish;
  end

  // Response side: random back-pressure, plus one long hold-off while requests keep coming.
  initial begin
    int  choke_left;
    bit  choked;
    choke_left = 0;
    choked = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (choke_go && !choked) begin
        choked = 1'b1;
        choke_left = CHOKE_CYCLES;
      end
      if (choke_left > 0) begin
        out_ready <= 1'b0;
        choke_left--;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Valid is only lowered when an idle gap follows, so it never toggles within one step.
  task automatic send_req(logic [bsd_pkg::FUNC_W-1:0] f, logic [bsd_pkg::VALUE_W-1:0] v,
                          logic [bsd_pkg::COUNT_W-1:0] c);
    bsd_pkg::in_req_t r;
    r.func  = f;
    r.value = v;
    r.count = c;
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 37);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic set_capacity(logic [bsd_pkg::CAP_W-1:0] cap);
    in_valid <= 1'b0;
    do @(posedge clk); while (rsp_waiting != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Pushes are the most common operation, with values mostly from a small pool, so duplicates and deletes find matches.
  task automatic send_random(int n);
    int                          pick;
    logic [bsd_pkg::FUNC_W-1:0]  f;
    logic [bsd_pkg::VALUE_W-1:0] v;
    logic [bsd_pkg::COUNT_W-1:0] c;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      f = bsd_pkg::FUNC_PUSH;
      else if (pick < 45) f = bsd_pkg::FUNC_PUSH_UNIQUE;
      else if (pick < 60) f = bsd_pkg::FUNC_POP;
      else if (pick < 70) f = bsd_pkg::FUNC_PEEK;
      else if (pick < 80) f = bsd_pkg::FUNC_DEL_FIRST;
      else if (pick < 89) f = bsd_pkg::FUNC_DEL_ALL;
      else if (pick < 97) f = bsd_pkg::FUNC_CLEAR;
      else                f = FUNC_UNDEF;
      if ($urandom_range(0, 99) < 75) v = value_pool[$urandom_range(0, 5)];
      else                            v = bsd_pkg::VALUE_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 60)      c = bsd_pkg::COUNT_W'($urandom_range(0, 4));
      else if (pick < 90) c = bsd_pkg::COUNT_W'($urandom_range(0, 16));
      else                c = bsd_pkg::COUNT_W'($urandom_range(0, 31));
      send_req(f, v, c);
    end
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_req      <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    calm        <= 1'b0;
    choke_go    <= 1'b0;
    n_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, duplicates, full-range values and counts, deletes, an undefined code, clear.
    send_req(bsd_pkg::FUNC_POP, 16'h0000, 5'd3);
    send_req(bsd_pkg::FUNC_PEEK, 16'h0000, 5'd16);
    send_req(bsd_pkg::FUNC_PUSH, 16'h0000, 5'd0);
    send_req(bsd_pkg::FUNC_PUSH, 16'hFFFF, 5'd31);
    send_req(bsd_pkg::FUNC_PUSH_UNIQUE, 16'hFFFF, 5'd0);
    send_req(bsd_pkg::FUNC_PUSH_UNIQUE, 16'h1234, 5'd0);
    send_req(bsd_pkg::FUNC_PUSH, 16'hFFFF, 5'd0);
    send_req(bsd_pkg::FUNC_PEEK, 16'h0000, 5'd0);
    send_req(bsd_pkg::FUNC_PEEK, 16'h0000, 5'd31);
    send_req(bsd_pkg::FUNC_POP, 16'h0000, 5'd2);
    send_req(bsd_pkg::FUNC_PUSH, 16'hA5A5, 5'd0);
    send_req(bsd_pkg::FUNC_PUSH, 16'hA5A5, 5'd0);
    send_req(bsd_pkg::FUNC_PUSH, 16'h5A5A, 5'd0);
    send_req(bsd_pkg::FUNC_DEL_FIRST, 16'hA5A5, 5'd0);
    send_req(bsd_pkg::FUNC_DEL_ALL, 16'hFFFF, 5'd0);
    send_req(bsd_pkg::FUNC_DEL_ALL, 16'h7777, 5'd0);
    send_req(bsd_pkg::FUNC_DEL_FIRST, 16'h7777, 5'd0);
    send_req(FUNC_UNDEF, 16'hFFFF, 5'd31);
    send_req(bsd_pkg::FUNC_POP, 16'h0000, 5'd31);
    send_req(bsd_pkg::FUNC_CLEAR, 16'h0000, 5'd0);
    send_req(bsd_pkg::FUNC_PUSH, 16'h8001, 5'd0);
    send_req(bsd_pkg::FUNC_CLEAR, 16'hFFFF, 5'd31);
    send_req(bsd_pkg::FUNC_PEEK, 16'h0000, 5'd1);

    // Capacity is changed without clearing, so a phase with a lower capacity can start over-full.
    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(cap_plan[p]);
      if (p == 2) choke_go <= 1'b1;
      calm <= (p == 5);
      send_random(PHASE_REQS);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (rsp_waiting != 0);
    repeat (40) @(posedge clk);
    $display("%0d requests over %0d capacity settings, with one long response stall",
             n_sent, N_PHASES);
    $display("%0d responses compared, %0d mismatches", rsp_seen, mismatches);
    if (mismatches == 0 && rsp_waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ bounded_stack_with_dedup_delete_core.f @@
hw/rtl/bsd_pkg.sv
hw/rtl/bsd_cell.sv
hw/rtl/bounded_stack_with_dedup_delete_core.sv
dv/bounded_stack_checker.sv
dv/bounded_stack_with_dedup_delete_core_test.sv
